// ===== rtl/fqs_pkg.sv =====
// fqs_pkg: shared types and codes of the fifo queue with search
// used by fqs_store and fifo_queue_with_search_unit, no dependencies
package fqs_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 3;
    localparam int POS_W          = 5;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_INSERT = 2'd0;
    localparam t_mode MODE_DELETE = 2'd1;
    localparam t_mode MODE_SEARCH = 2'd2;

    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status STAT_OK       = 3'd0;
    localparam t_status STAT_EMPTY    = 3'd1;
    localparam t_status STAT_FULL     = 3'd2;
    localparam t_status STAT_NOTFOUND = 3'd3;
    localparam t_status STAT_FOUND    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEQ,
        S_READ,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_cmd;

endpackage

// ===== rtl/fqs_store.sv =====
// fqs_store: ring storage of the queue, one write port and one registered read port
// depends on fqs_pkg
module fqs_store
    import fqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  t_mem_cmd              i_cmd,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fifo_queue_with_search_unit.sv =====
// fifo_queue_with_search_unit: bounded fifo of words with delete and key search
// depends on fqs_pkg and fqs_store
//
// usage
//   input channel i_valid/o_ready carries one request beat: i_mode (0 insert,
//   1 delete oldest, 2 search) and i_value (value to insert or search key).
//   output channel o_valid/i_ready carries result beats: o_status, o_data_out,
//   o_position and o_last, which marks the final beat of a request.
//   one request at a time: o_ready is high only while the sequencer is idle.
//   insert writes in the exec state; delete reads the head in exec and returns
//   it in the dequeue state; search passes a read and a compare state per entry,
//   then a finish state. one storage read per entry, on the single registered
//   read port, sets the scan rate. mode 3 is taken and dropped with no result.
//   a search keeps one found match pending until the next match or the end of
//   the scan, so each match beat goes out once its successor is known.
//   results pass through one output register; when the receiver stalls the
//   sequencer waits on that register and resumes when it drains.
//   reset (synchronous, active low) empties the queue; stored words are not
//   cleared and are never read before being written.
module fifo_queue_with_search_unit
    import fqs_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [VALUE_W-1:0] o_data_out,
    output logic [POS_W-1:0]          o_position,
    output logic                      o_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [AW-1:0]         r_tail, n_tail;
    logic [OW-1:0]         r_occ, n_occ;
    t_mode                 r_mode, n_mode;
    logic [DATA_WIDTH-1:0] r_key, n_key;
    logic [AW-1:0]         r_slot, n_slot;
    logic [AW-1:0]         r_cnt, n_cnt;
    logic                  r_pend_valid, n_pend_valid;
    logic [VALUE_W-1:0]    r_pend_data, n_pend_data;
    logic [POS_W-1:0]      r_pend_pos, n_pend_pos;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [VALUE_W-1:0]    r_out_data, n_out_data;
    logic [POS_W-1:0]      r_out_pos, n_out_pos;
    logic                  r_out_last, n_out_last;

    t_mem_cmd              w_cmd;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [DATA_WIDTH-1:0] w_vin;
    logic [DATA_WIDTH+VALUE_W-1:0] w_vin_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] w_rd_ext;
    logic [VALUE_W-1:0]    w_rd_out;
    logic [AW:0]           w_pos_full;
    logic [AW+POS_W:0]     w_pos_ext;
    logic [POS_W-1:0]      w_pos;
    logic                  w_out_free;
    logic                  w_empty;
    logic                  w_full;
    logic                  w_match;
    logic                  w_last_entry;
    logic                  w_hold;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    fqs_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .i_waddr (r_tail),
        .i_wdata (r_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_vin_ext    = {{DATA_WIDTH{1'b0}}, i_value};
    assign w_vin        = w_vin_ext[DATA_WIDTH-1:0];
    assign w_rd_ext     = {{VALUE_W{w_rdata[DATA_WIDTH-1]}}, w_rdata};
    assign w_rd_out     = w_rd_ext[VALUE_W-1:0];
    assign w_pos_full   = {1'b0, r_cnt} + (AW+1)'(1);
    assign w_pos_ext    = {{POS_W{1'b0}}, w_pos_full};
    assign w_pos        = w_pos_ext[POS_W-1:0];
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_empty      = (r_occ == '0);
    assign w_full       = (r_occ == OW'(DEPTH));
    assign w_match      = (w_rdata == r_key);
    assign w_last_entry = ((OW'(r_cnt) + OW'(1)) == r_occ);
    assign w_hold       = w_match && r_pend_valid && !w_out_free;
    assign w_raddr      = (r_state == S_READ) ? r_slot : r_head;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_data_out = $signed(r_out_data);
    assign o_position = r_out_pos;
    assign o_last     = r_out_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        MODE_INSERT, MODE_DELETE, MODE_SEARCH: n_state = S_EXEC;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (w_out_free) n_state = S_IDLE;
                    end
                    MODE_DELETE: begin
                        if (!w_empty) n_state = S_DEQ;
                        else if (w_out_free) n_state = S_IDLE;
                    end
                    MODE_SEARCH: begin
                        if (!w_empty) n_state = S_READ;
                        else if (w_out_free) n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_DEQ: begin
                if (w_out_free) n_state = S_IDLE;
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!w_hold) n_state = w_last_entry ? S_FIN : S_READ;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        w_cmd        = '0;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_mode       = r_mode;
        n_key        = r_key;
        n_slot       = r_slot;
        n_cnt        = r_cnt;
        n_pend_valid = r_pend_valid;
        n_pend_data  = r_pend_data;
        n_pend_pos   = r_pend_pos;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_pos    = r_out_pos;
        n_out_last   = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode;
                    n_key  = w_vin;
                end
            end
            S_EXEC: begin
                unique case (r_mode)
                    MODE_INSERT: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_data  = '0;
                            n_out_pos   = '0;
                            n_out_last  = 1'b1;
                            if (w_full) begin
                                n_out_status = STAT_FULL;
                            end else begin
                                n_out_status = STAT_OK;
                                w_cmd.wr_en  = 1'b1;
                                n_tail       = wrap_inc(r_tail);
                                n_occ        = r_occ + OW'(1);
                            end
                        end
                    end
                    MODE_DELETE, MODE_SEARCH: begin
                        if (w_empty) begin
                            if (w_out_free) begin
                                n_out_valid  = 1'b1;
                                n_out_status = STAT_EMPTY;
                                n_out_data   = '0;
                                n_out_pos    = '0;
                                n_out_last   = 1'b1;
                            end
                        end else if (r_mode == MODE_DELETE) begin
                            w_cmd.rd_en = 1'b1;
                        end else begin
                            n_slot       = r_head;
                            n_cnt        = '0;
                            n_pend_valid = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            S_DEQ: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STAT_OK;
                    n_out_data   = w_rd_out;
                    n_out_pos    = '0;
                    n_out_last   = 1'b1;
                    n_head       = wrap_inc(r_head);
                    n_occ        = r_occ - OW'(1);
                end
            end
            S_READ: begin
                w_cmd.rd_en = 1'b1;
            end
            S_CMP: begin
                if (!w_hold) begin
                    if (w_match) begin
                        if (r_pend_valid) begin
                            n_out_valid  = 1'b1;
                            n_out_status = STAT_FOUND;
                            n_out_data   = r_pend_data;
                            n_out_pos    = r_pend_pos;
                            n_out_last   = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_data  = w_rd_out;
                        n_pend_pos   = w_pos;
                    end
                    n_slot = wrap_inc(r_slot);
                    n_cnt  = r_cnt + AW'(1);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    if (r_pend_valid) begin
                        n_out_status = STAT_FOUND;
                        n_out_data   = r_pend_data;
                        n_out_pos    = r_pend_pos;
                    end else begin
                        n_out_status = STAT_NOTFOUND;
                        n_out_data   = '0;
                        n_out_pos    = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_occ        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_occ        <= n_occ;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_cnt        <= n_cnt;
        r_pend_data  <= n_pend_data;
        r_pend_pos   <= n_pend_pos;
        r_out_status <= n_out_status;
        r_out_data   <= n_out_data;
        r_out_pos    <= n_out_pos;
        r_out_last   <= n_out_last;
    end

    // empty or full ring has head and tail on the same slot
    a_ring_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_empty || w_full) |-> (r_head == r_tail))
        else $error("ring pointers disagree with occupancy");

    // occupancy moves by at most one per request step
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 ((r_occ == $past(r_occ)) || (r_occ == $past(r_occ) + OW'(1))
            || (r_occ == $past(r_occ) - OW'(1))))
        else $error("occupancy jumped");

    // a pending match exists only inside a search scan
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> ((r_state == S_READ) || (r_state == S_CMP) || (r_state == S_FIN)))
        else $error("pending match outside search");

    // a found beat always carries a nonzero position when it fits the field
    a_found_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == STAT_FOUND) && (DEPTH < 32)) |-> (r_out_pos != '0))
        else $error("found beat without position");

    // a real request leaves idle for the sequencer
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && ((i_mode == MODE_INSERT) || (i_mode == MODE_DELETE)
            || (i_mode == MODE_SEARCH))) |=> (r_state == S_EXEC))
        else $error("request beat not taken up");

endmodule

// ===== test/testbench.sv =====
// testbench: drives insert, delete and search requests into fifo_queue_with_search_unit
// and checks every result beat against a queue predictor held in a scoreboard class
// depends on fqs_pkg and the rtl of fifo_queue_with_search_unit
`timescale 1ns / 100ps

module testbench;
    import fqs_pkg::*;

    localparam int    QUEUE_DEPTH  = DEPTH_DEF;
    localparam int    ITEM_COUNT   = 310;
    localparam int    IDLE_LIMIT   = 5000;
    localparam int    DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam t_mode MODE_UNUSED  = 2'd3;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] data;
        logic [POS_W-1:0]   position;
        logic               last;
    } queue_reply_t;

    class queue_scoreboard;
        logic [VALUE_W-1:0] slots [QUEUE_DEPTH];
        int unsigned        head = 0;
        int unsigned        tail = 0;
        int unsigned        fill = 0;
        queue_reply_t       replies [$];
        int unsigned        per_mode [4] = '{0, 0, 0, 0};
        int unsigned        errors = 0;
        int unsigned        beats = 0;
        int unsigned        match_count = 0;
        int unsigned        full_hits = 0;
        int unsigned        empty_hits = 0;

        function void add_reply(t_status status, logic [VALUE_W-1:0] data,
                                int unsigned position, logic last);
            queue_reply_t r;
            r.status   = status;
            r.data     = data;
            r.position = POS_W'(position);
            r.last     = last;
            replies.push_back(r);
        endfunction

        function void note_request(t_mode mode, logic [VALUE_W-1:0] value);
            int unsigned slot;
            int unsigned hits;
            per_mode[mode]++;
            case (mode)
                MODE_INSERT: begin
                    if (fill == QUEUE_DEPTH) begin
                        add_reply(STAT_FULL, '0, 0, 1'b1);
                        full_hits++;
                    end else begin
                        slots[tail] = value;
                        tail = (tail + 1) % QUEUE_DEPTH;
                        fill++;
                        add_reply(STAT_OK, '0, 0, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    if (fill == 0) begin
                        add_reply(STAT_EMPTY, '0, 0, 1'b1);
                        empty_hits++;
                    end else begin
                        add_reply(STAT_OK, slots[head], 0, 1'b1);
                        head = (head + 1) % QUEUE_DEPTH;
                        fill--;
                    end
                end
                MODE_SEARCH: begin
                    if (fill == 0) begin
                        add_reply(STAT_EMPTY, '0, 0, 1'b1);
                        empty_hits++;
                    end else begin
                        slot = head;
                        hits = 0;
                        for (int unsigned i = 0; i < fill; i++) begin
                            if (slots[slot] == value) begin
                                add_reply(STAT_FOUND, slots[slot], i + 1, 1'b0);
                                hits++;
                            end
                            slot = (slot + 1) % QUEUE_DEPTH;
                        end
                        if (hits == 0) begin
                            add_reply(STAT_NOTFOUND, '0, 0, 1'b1);
                        end else begin
                            replies[replies.size() - 1].last = 1'b1;
                            match_count += hits;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [VALUE_W-1:0] want,
                              logic [VALUE_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_status status, logic [VALUE_W-1:0] data,
                                   logic [POS_W-1:0] position, logic last);
            queue_reply_t want;
            beats++;
            if (replies.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none, actual status %0d data %0h pos %0d",
                         $time, status, data, position);
                return;
            end
            want = replies.pop_front();
            compare("status", want.status, status);
            compare("data_out", want.data, data);
            compare("position", want.position, position);
            compare("last", want.last, last);
        endfunction

        function int unsigned pending();
            return replies.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic [1:0]                i_mode = MODE_INSERT;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic signed [VALUE_W-1:0] o_data_out;
    logic [POS_W-1:0]          o_position;
    logic                      o_last;

    queue_scoreboard    sb;
    int unsigned        burst_left = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        stall_tick = 0;
    int unsigned        stall_style = 0;
    logic [VALUE_W-1:0] key_pool [4];

    fifo_queue_with_search_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data_out (o_data_out),
        .o_position (o_position),
        .o_last     (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_status, o_data_out, o_position, o_last);
        end
    end

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0) begin
            stall_style <= $urandom_range(0, 3);
        end
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (stall_tick % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input t_mode mode, input logic [VALUE_W-1:0] value);
        int unsigned gap;
        i_valid <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(mode, value);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned        counted;
        int unsigned        pick;
        bit                 filling;
        t_mode              mode;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] probe_key;

        sb = new;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = $urandom_range(1, 6);
        probe_key   = 32'h5a5a_a5a5;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue cases and the unused mode
        send_request(MODE_DELETE, $urandom);
        send_request(MODE_SEARCH, 32'h0);
        send_request(MODE_UNUSED, $urandom);
        // fill to the brim with extremes and a repeated key
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            case (k)
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                2: value = 32'h0000_0000;
                3: value = 32'hffff_ffff;
                default: value = (k % 2 == 0) ? probe_key : k;
            endcase
            send_request(MODE_INSERT, value);
        end
        send_request(MODE_INSERT, $urandom);
        send_request(MODE_SEARCH, probe_key);
        send_request(MODE_SEARCH, 32'h7fff_ffff);
        send_request(MODE_SEARCH, 32'h1234_5678);
        send_request(MODE_DELETE, $urandom);
        send_request(MODE_INSERT, 32'hffff_ffff);
        wait_for_drain();

        counted = 0;
        filling = 1'b1;
        while (counted < ITEM_COUNT) begin
            if (sb.fill == QUEUE_DEPTH) begin
                filling = 1'b0;
            end else if (sb.fill == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 40) == 0) begin
                filling = !filling;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                mode = MODE_UNUSED;
            end else if (pick < 45) begin
                mode = filling ? MODE_INSERT : MODE_DELETE;
            end else if (pick < 65) begin
                mode = filling ? MODE_DELETE : MODE_INSERT;
            end else begin
                mode = MODE_SEARCH;
            end
            value = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 3)] : $urandom;
            send_request(mode, value);
            if (mode != MODE_UNUSED) begin
                counted++;
                if (counted % 70 == 0) begin
                    wait_for_drain();
                end
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        $display("covered %0d inserts, %0d deletes, %0d searches, %0d ignored requests",
                 sb.per_mode[MODE_INSERT], sb.per_mode[MODE_DELETE],
                 sb.per_mode[MODE_SEARCH], sb.per_mode[MODE_UNUSED]);
        $display("%0d result beats, %0d matches, %0d full and %0d empty reports, %0d errors",
                 sb.beats, sb.match_count, sb.full_hits, sb.empty_hits, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fqs_pkg.sv
rtl/fqs_store.sv
rtl/fifo_queue_with_search_unit.sv
test/testbench.sv
